[sv/rba_pkg.sv]
// Package for the region bump allocator: table sizing, operation, status and
// register codes, and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package rba_pkg;

  // Region table sizing.
  localparam int MAX_REGIONS = 64;
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // Operation codes carried by an input transfer; code 3 is unused.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_GRANT = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;

  // Register index, taken from the word address of the configuration port.
  localparam logic REG_REGION_COUNT = 1'b0;

  // One stored region: usable flag, precomputed 65-bit end and base.
  typedef struct packed {
    logic        usable;
    logic [64:0] end_addr;
    logic [63:0] base;
  } region_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       mem_we;
    logic       cur_clear;
    logic       cur_inc;
    logic       fp_zero;
    logic       fp_load_base;
    logic       fp_grant;
    logic       out_load;
    logic [1:0] status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       exhausted;
    logic       usable;
    logic       fits;
  } dp_sts_t;

endpackage

[sv/rba_if.sv]
// Valid/ready channel interfaces for the input items and the results of the
// region bump allocator. No dependencies.
`timescale 1ns / 1ps

interface rba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  entry_index;
  logic [63:0] entry_base;
  logic [63:0] entry_length;
  logic [7:0]  entry_type;
  logic [63:0] alloc_size;

  modport source (
    output valid, operation, entry_index, entry_base, entry_length, entry_type,
           alloc_size,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, entry_base, entry_length, entry_type,
           alloc_size,
    output ready
  );
endinterface

interface rba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] address;
  logic [6:0]  region_now;

  modport source (
    output valid, status, address, region_now,
    input  ready
  );
  modport sink (
    input  valid, status, address, region_now,
    output ready
  );
endinterface

[sv/rba_datapath.sv]
// Datapath of the region bump allocator: item registers, region table memory,
// current index, free pointer, fit test and result register. Uses rba_pkg.
`timescale 1ns / 1ps

module rba_datapath
  import rba_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    in_operation,
  input  logic [5:0]    in_entry_index,
  input  logic [63:0]   in_entry_base,
  input  logic [63:0]   in_entry_length,
  input  logic [7:0]    in_entry_type,
  input  logic [63:0]   in_alloc_size,
  input  logic [6:0]    region_count,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  output logic [1:0]    out_status,
  output logic [63:0]   out_address,
  output logic [6:0]    out_region_now
);

  // Captured input item.
  logic [1:0]    op_r;
  logic [5:0]    index_r;
  logic [63:0]   base_r;
  logic [63:0]   length_r;
  logic [7:0]    type_r;
  logic [63:0]   size_r;

  // Allocator state.
  logic [CNT_W-1:0] cur_r;
  logic [CNT_W-1:0] cur_nxt;
  logic [63:0]      fp_r;
  logic [63:0]      fp_nxt;
  logic [63:0]      addr_r;

  // Region table and its registered read port.
  region_entry_t mem [MAX_REGIONS];
  region_entry_t rd_data_r;

  // Result register.
  logic [1:0]  res_status_r;
  logic [63:0] res_address_r;
  logic [6:0]  res_region_r;

  logic [CNT_W-1:0] valid_count;
  logic [64:0]      req_end;
  logic             slot_ok;
  region_entry_t    wr_entry;

  // A count above the table depth is clamped to the depth.
  assign valid_count = (int'(region_count) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
                                                          : CNT_W'(region_count);

  // The request fits when the pointer plus size neither passes 2^64 - 1
  // nor the region end.
  assign req_end = {1'b0, fp_r} + {1'b0, size_r};

  assign slot_ok = int'(index_r) < MAX_REGIONS;

  assign wr_entry.usable   = (type_r == 8'd0);
  assign wr_entry.end_addr = {1'b0, base_r} + {1'b0, length_r};
  assign wr_entry.base     = base_r;

  assign sts.op        = op_r;
  assign sts.exhausted = (cur_r >= valid_count);
  assign sts.usable    = rd_data_r.usable;
  assign sts.fits      = !req_end[64] && (req_end <= rd_data_r.end_addr);

  // Capture the item at the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_operation;
      index_r  <= in_entry_index;
      base_r   <= in_entry_base;
      length_r <= in_entry_length;
      type_r   <= in_entry_type;
      size_r   <= in_alloc_size;
    end
  end

  // Table write for a load and a read of the current entry every cycle.
  always_ff @(posedge clk) begin
    if (cmd.mem_we && slot_ok) begin
      mem[IDX_W'(index_r)] <= wr_entry;
    end
    rd_data_r <= mem[cur_r[IDX_W-1:0]];
  end

  // Next current index and free pointer.
  always_comb begin
    cur_nxt = cur_r;
    if (cmd.cur_clear) begin
      cur_nxt = '0;
    end else if (cmd.cur_inc) begin
      cur_nxt = cur_r + CNT_W'(1);
    end
    fp_nxt = fp_r;
    if (cmd.fp_zero) begin
      fp_nxt = '0;
    end else if (cmd.fp_load_base) begin
      fp_nxt = rd_data_r.base;
    end else if (cmd.fp_grant) begin
      fp_nxt = req_end[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      fp_r  <= '0;
    end else begin
      cur_r <= cur_nxt;
      fp_r  <= fp_nxt;
    end
  end

  // Granted address; zero unless this item is granted.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r <= '0;
    end else if (cmd.fp_grant) begin
      addr_r <= fp_r;
    end
  end

  // Result register, loaded when the output slot is free.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_status_r  <= cmd.status;
      res_address_r <= addr_r;
      res_region_r  <= 7'(cur_r);
    end
  end

  assign out_status     = res_status_r;
  assign out_address    = res_address_r;
  assign out_region_now = res_region_r;

endmodule

[sv/rba_ctrl.sv]
// Controller state machine of the region bump allocator: input and output
// handshakes and the sequencing of load, start and allocate. Uses rba_pkg.
`timescale 1ns / 1ps

module rba_ctrl
  import rba_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEEK_WAIT,
    S_SEEK_CHK,
    S_FIT,
    S_DONE
  } state_t;

  state_t     state_r;
  state_t     state_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state, result status and datapath commands.
  always_comb begin
    cmd           = '0;
    cmd.status    = status_r;
    state_nxt     = state_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          status_nxt  = ST_DONE;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          OP_LOAD: begin
            cmd.mem_we = 1'b1;
            state_nxt  = S_DONE;
          end
          OP_START: begin
            cmd.cur_clear = 1'b1;
            state_nxt     = S_SEEK_WAIT;
          end
          OP_ALLOC: begin
            // The current entry was read at the input transfer.
            if (sts.exhausted) begin
              status_nxt = ST_OOM;
              state_nxt  = S_DONE;
            end else if (sts.fits) begin
              cmd.fp_grant = 1'b1;
              status_nxt   = ST_GRANT;
              state_nxt    = S_DONE;
            end else begin
              cmd.cur_inc = 1'b1;
              state_nxt   = S_SEEK_WAIT;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SEEK_WAIT: begin
        // The entry at the new index is being read; stop at the table end.
        if (sts.exhausted) begin
          if (sts.op == OP_START) begin
            cmd.fp_zero = 1'b1;
          end else begin
            status_nxt = ST_OOM;
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SEEK_CHK;
        end
      end
      S_SEEK_CHK: begin
        if (sts.usable) begin
          cmd.fp_load_base = 1'b1;
          state_nxt = (sts.op == OP_START) ? S_DONE : S_FIT;
        end else begin
          cmd.cur_inc = 1'b1;
          state_nxt   = S_SEEK_WAIT;
        end
      end
      S_FIT: begin
        if (sts.fits) begin
          cmd.fp_grant = 1'b1;
          status_nxt   = ST_GRANT;
          state_nxt    = S_DONE;
        end else begin
          cmd.cur_inc = 1'b1;
          state_nxt   = S_SEEK_WAIT;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/region_bump_allocator_top.sv]
// Region bump allocator: input and result channels, an APB-style register for
// the region count, and the controller and datapath. Uses rba_pkg, rba_if,
// rba_ctrl and rba_datapath.
//
// Usage: load table entries with load items, send a start item, then send
// allocate items; each item gives exactly one result transfer.
// Channels: in_ch carries items, out_ch carries status, address and the
// current region index. Both use valid/ready; a transfer happens when both
// are high at a rising clock edge.
// Load, an unused code, and an allocate that fits the current region or finds
// the table exhausted go from dispatch straight to the done state. Start and
// a failed fit walk the table: each step waits for the registered table read,
// then checks the entry; an allocate tests each usable region for a fit.
// An item is accepted only in the idle state, after the result of the previous
// item has been loaded into the output register.
// A new item is accepted while the previous result still waits in the output
// register; when the receiver stalls, the finished result of that item waits
// until the output register frees, and nothing further is accepted.
// Reset (synchronous, rst_n low) clears the region count, current index and
// free pointer; table entries stay undefined until loaded.
`timescale 1ns / 1ps

module region_bump_allocator_top
  import rba_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rba_in_if.sink      in_ch,
  rba_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [6:0] region_count_r;
  logic       reg_sel;

  // Configuration register: written in the access cycle of a write transfer.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_REGION_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      region_count_r <= pwdata[6:0];
    end
  end

  assign prdata = reg_sel ? {25'd0, region_count_r} : 32'd0;

  rba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rba_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operation    (in_ch.operation),
    .in_entry_index  (in_ch.entry_index),
    .in_entry_base   (in_ch.entry_base),
    .in_entry_length (in_ch.entry_length),
    .in_entry_type   (in_ch.entry_type),
    .in_alloc_size   (in_ch.alloc_size),
    .region_count    (region_count_r),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_ch.status),
    .out_address     (out_ch.address),
    .out_region_now  (out_ch.region_now)
  );

endmodule

[sv/rba_checker.sv]
// Port-level checks for the region bump allocator and the bind that attaches
// them to region_bump_allocator_top. Uses rba_pkg.
`timescale 1ns / 1ps

module rba_checker
  import rba_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_address,
  input logic [6:0]  out_region_now
);

  // Only one item is in work: no transfer in the cycle after one.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in work");

  // An address is shown only with a grant.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_GRANT) |-> (out_address == 64'd0))
    else $error("nonzero address without a grant");

  // The region index never passes the table depth.
  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_region_now) <= MAX_REGIONS))
    else $error("region index beyond table depth");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_address)
       && $stable(out_region_now)))
    else $error("stalled result changed");

endmodule

bind region_bump_allocator_top rba_checker u_rba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_address    (out_ch.address),
  .out_region_now (out_ch.region_now)
);

[tb/tb_top.sv]
// Self-checking bench for region_bump_allocator_top: loads region tables,
// starts and allocates, and checks each result transfer against a predictor.
// Depends on rba_pkg, rba_if and the region_bump_allocator_top RTL.
`timescale 1ns / 1ps

module tb_top;
  import rba_pkg::*;

  // The unused operation code; the block must treat it as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  entry_index;
    logic [63:0] entry_base;
    logic [63:0] entry_length;
    logic [7:0]  entry_type;
    logic [63:0] alloc_size;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] address;
    logic [6:0]  region_now;
  } alloc_reply_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rba_in_if  in_ch ();
  rba_out_if out_ch ();

  region_bump_allocator_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // Stimulus and expected replies.
  alloc_req_t   queued_requests[$];
  alloc_reply_t predicted_replies[$];
  int           sent_count = 0;
  int           accepted_count = 0;
  int           fault_count = 0;
  int           cycles = 0;
  bit           idle_en = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;
  bit           slot_loaded[64];

  // Predictor state: the region table, the walk position and the free pointer.
  logic [63:0]  tbl_base[64];
  logic [63:0]  tbl_len[64];
  bit           tbl_usable[64];
  int unsigned  cur_region = 0;
  logic [63:0]  free_ptr = '0;
  int unsigned  region_cnt = 0;

  alloc_req_t   took_req;
  alloc_reply_t want_reply;
  alloc_req_t   next_req;

  function automatic int unsigned live_regions();
    return (region_cnt > MAX_REGIONS) ? MAX_REGIONS : region_cnt;
  endfunction

  function automatic int unsigned next_usable_region(input int unsigned from);
    int unsigned i;
    for (i = from; i < live_regions(); i++) begin
      if (tbl_usable[i]) return i;
    end
    return live_regions();
  endfunction

  // The end is taken in 65 bits, and a request whose top passes 2^64 - 1 never fits.
  function automatic bit request_fits(input int unsigned idx, input logic [63:0] size);
    logic [64:0] limit_addr;
    logic [64:0] top;
    limit_addr = {1'b0, tbl_base[idx]} + {1'b0, tbl_len[idx]};
    top = {1'b0, free_ptr} + {1'b0, size};
    return !top[64] && (top <= limit_addr);
  endfunction

  function automatic alloc_reply_t predict_reply(input alloc_req_t req);
    alloc_reply_t reply;
    bit searching;
    reply = '0;
    reply.status = ST_DONE;
    case (req.operation)
      OP_LOAD: begin
        tbl_base[req.entry_index] = req.entry_base;
        tbl_len[req.entry_index] = req.entry_length;
        tbl_usable[req.entry_index] = (req.entry_type == 8'h00);
      end
      OP_START: begin
        cur_region = next_usable_region(0);
        free_ptr = (cur_region < live_regions()) ? tbl_base[cur_region] : 64'h0;
      end
      OP_ALLOC: begin
        // A failed fit gives up the region and moves to the next usable one.
        reply.status = ST_OOM;
        searching = 1'b1;
        while (searching && cur_region < live_regions()) begin
          if (request_fits(cur_region, req.alloc_size)) begin
            reply.status = ST_GRANT;
            reply.address = free_ptr;
            free_ptr = free_ptr + req.alloc_size;
            searching = 1'b0;
          end else begin
            cur_region = next_usable_region(cur_region + 1);
            if (cur_region < live_regions()) free_ptr = tbl_base[cur_region];
          end
        end
      end
      default: ;
    endcase
    reply.region_now = cur_region[6:0];
    return reply;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) begin
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Monitor: check result transfers, then predict for each accepted item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_replies.size() == 0) begin
          note_mismatch("result with no item pending", 64'h0, out_ch.address);
        end else begin
          want_reply = predicted_replies.pop_front();
          if (out_ch.status !== want_reply.status)
            note_mismatch("status", 64'(want_reply.status), 64'(out_ch.status));
          if (out_ch.address !== want_reply.address)
            note_mismatch("address", want_reply.address, out_ch.address);
          if (out_ch.region_now !== want_reply.region_now)
            note_mismatch("region_now", 64'(want_reply.region_now),
                          64'(out_ch.region_now));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        took_req.operation = in_ch.operation;
        took_req.entry_index = in_ch.entry_index;
        took_req.entry_base = in_ch.entry_base;
        took_req.entry_length = in_ch.entry_length;
        took_req.entry_type = in_ch.entry_type;
        took_req.alloc_size = in_ch.alloc_size;
        predicted_replies.push_back(predict_reply(took_req));
        accepted_count++;
      end
    end
  end

  // Driver: presents the next queued item once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.operation <= OP_LOAD;
      in_ch.entry_index <= '0;
      in_ch.entry_base <= '0;
      in_ch.entry_length <= '0;
      in_ch.entry_type <= '0;
      in_ch.alloc_size <= '0;
    end else if (sent_count == accepted_count) begin
      if (send_gap == 0 && idle_en && $urandom_range(0, 7) == 0)
        send_gap = $urandom_range(1, 16);
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (queued_requests.size() > 0) begin
        next_req = queued_requests.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= next_req.operation;
        in_ch.entry_index <= next_req.entry_index;
        in_ch.entry_base <= next_req.entry_base;
        in_ch.entry_length <= next_req.entry_length;
        in_ch.entry_type <= next_req.entry_type;
        in_ch.alloc_size <= next_req.alloc_size;
        sent_count++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure in random bursts.
  always @(negedge clk) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 16);
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic alloc_req_t make_req(input logic [1:0] op, input logic [5:0] idx,
                                          input logic [63:0] base, input logic [63:0] len,
                                          input logic [7:0] kind, input logic [63:0] size);
    alloc_req_t req;
    req.operation = op;
    req.entry_index = idx;
    req.entry_base = base;
    req.entry_length = len;
    req.entry_type = kind;
    req.alloc_size = size;
    return req;
  endfunction

  task automatic push_load(input logic [5:0] idx, input logic [63:0] base,
                           input logic [63:0] len, input logic [7:0] kind);
    queued_requests.push_back(make_req(OP_LOAD, idx, base, len, kind, rand64()));
    slot_loaded[idx] = 1'b1;
  endtask

  task automatic push_start();
    queued_requests.push_back(make_req(OP_START, 6'($urandom), rand64(), rand64(),
                                       8'($urandom), rand64()));
  endtask

  task automatic push_alloc(input logic [63:0] size);
    queued_requests.push_back(make_req(OP_ALLOC, 6'($urandom), rand64(), rand64(),
                                       8'($urandom), size));
  endtask

  task automatic push_noise();
    queued_requests.push_back(make_req(OP_UNUSED, 6'($urandom), rand64(), rand64(),
                                       8'($urandom), rand64()));
  endtask

  // Regions mostly modest in length, some near the top of the address space.
  task automatic push_random_load(input int idx);
    logic [63:0] base;
    logic [63:0] len;
    logic [7:0]  kind;
    case ($urandom_range(0, 7))
      0: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 70000));
      1: base = {32'h0, $urandom};
      default: base = rand64();
    endcase
    case ($urandom_range(0, 9))
      0: len = 64'h0;
      1: len = '1;
      2: len = rand64();
      default: len = 64'($urandom_range(1, 65536));
    endcase
    kind = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(1, 255));
    push_load(6'(idx), base, len, kind);
  endtask

  function automatic logic [63:0] random_size();
    case ($urandom_range(0, 19))
      0: return 64'h0;
      1: return '1;
      2: return rand64();
      3: return {32'h0, $urandom};
      default: return 64'($urandom_range(1, 12000));
    endcase
  endfunction

  task automatic drain_outstanding();
    while (queued_requests.size() != 0 || sent_count != accepted_count ||
           predicted_replies.size() != 0)
      @(posedge clk);
  endtask

  // Loads any slot the new count would expose, waits for the block to go idle,
  // then writes the count and reads it back over the register port.
  task automatic set_region_count(input logic [6:0] value);
    int i;
    int lim;
    lim = (value > MAX_REGIONS) ? MAX_REGIONS : value;
    for (i = 0; i < lim; i++) begin
      if (!slot_loaded[i]) push_random_load(i);
    end
    drain_outstanding();
    repeat (8) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_REGION_COUNT, 2'b00};
    pwdata <= {25'h0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    region_cnt = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[6:0] !== value)
      note_mismatch("region_count readback", 64'(value), 64'(prdata[6:0]));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase: a start, then mostly allocations mixed with restarts,
  // table reloads and unused codes.
  task automatic run_phase(input int count_value, input int n_items, input bit quiet);
    int k;
    int pick;
    set_region_count(7'(count_value));
    idle_en = !quiet;
    push_start();
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) push_start();
      else if (pick < 18) push_random_load($urandom_range(0, 63));
      else if (pick < 22) push_noise();
      else push_alloc(random_size());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_en = 1'b1;

    // Empty table: allocate, the unused code and start all find no region.
    push_alloc(64'h0);
    push_noise();
    push_start();
    push_load(6'd0, 64'h1000, 64'h100, 8'h00);
    push_load(6'd1, 64'h8000, 64'h40, 8'hFF);
    push_load(6'd2, 64'hFFFF_FFFF_FFFF_FF00, 64'h100, 8'h00);
    push_load(6'd3, 64'hFFFF_FFFF_FFFF_FFF0, '1, 8'h00);
    push_load(6'd63, '1, '1, 8'h80);
    set_region_count(7'd4);

    // Allocation after a start that found no region works on region 0 with a zero pointer.
    push_alloc(64'h10);
    push_start();
    push_alloc(64'h0);
    // Exact fill, then a zero size right at the region end.
    push_alloc(64'h100);
    push_alloc(64'h0);
    // Skips the unusable slot; the next region ends exactly at 2^64.
    push_alloc(64'hFF);
    push_alloc(64'h0);
    // The pointer would wrap, so move to the region whose end carries out.
    push_alloc(64'h1);
    push_alloc('1);
    push_alloc(64'h0);

    // Count lowered below the current index, then a restart and an allocation that runs dry.
    set_region_count(7'd2);
    push_alloc(64'h8);
    push_start();
    push_alloc(64'h200);

    run_phase(64, 90, 1'b0);
    run_phase(1, 80, 1'b0);
    run_phase(127, 90, 1'b0);
    run_phase(0, 60, 1'b1);
    run_phase(9, 90, 1'b0);
    run_phase(64, 90, 1'b0);
    run_phase($urandom_range(0, 127), 90, 1'b1);
    run_phase($urandom_range(0, 64), 90, 1'b0);
    run_phase(2, 80, 1'b0);
    run_phase(100, 90, 1'b0);
    run_phase($urandom_range(0, 127), 90, 1'b0);
    run_phase(64, 90, 1'b1);

    drain_outstanding();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
